// ===== rtl/spt_pkg.sv =====
// Package for the steady pitch tracker: word types, constants and helpers.
`default_nettype none
package spt_pkg;

  localparam int unsigned PitchW = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 31;
  localparam int unsigned ThrW   = 23;

  localparam logic [ThrW-1:0]          ThrReset      = 23'd655;
  localparam logic signed [PitchW-1:0] GoodPitchInit = 24'sd65536;
  localparam logic signed [TimeW:0]    OneSecond     = 33'sd65536;
  localparam logic [TimeW:0]           TwoSeconds    = 33'd131072;
  localparam logic [DurW-1:0]          DurMax        = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [PitchW-1:0] pitch;
    logic signed [TimeW-1:0]  track_time;
  } in_word_t;

  typedef struct packed {
    logic [DurW-1:0]          steady_duration;
    logic signed [PitchW-1:0] steady_value;
  } out_word_t;

  // input register contents handed to the tracker
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  // clamp a 33-bit signed value to the signed 32-bit range
  function automatic logic signed [TimeW-1:0] sat32(input logic signed [TimeW:0] v);
    logic signed [TimeW-1:0] r;
    if (v[TimeW] != v[TimeW-1]) begin
      r = v[TimeW] ? {1'b1, {(TimeW-1){1'b0}}} : {1'b0, {(TimeW-1){1'b1}}};
    end else begin
      r = v[TimeW-1:0];
    end
    return r;
  endfunction

  // magnitude of a 33-bit difference of two 32-bit values (never -2^32)
  function automatic logic [TimeW:0] abs33(input logic signed [TimeW:0] v);
    logic [TimeW:0] r;
    r = v[TimeW] ? 33'(-v) : 33'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spt_in_stage.sv =====
// Input register of the steady pitch tracker with its stall logic.
`default_nettype none
module spt_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire spt_pkg::in_word_t in_word_i,
  input  wire logic              adv_i,
  output spt_pkg::stage_t        stage_o
);

  logic              valid_q, valid_d;
  spt_pkg::in_word_t word_q;
  logic              accept;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule
`default_nettype wire

// ===== rtl/spt_track.sv =====
// Tracking state, per-word update logic and result register.
`default_nettype none
module spt_track (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spt_pkg::stage_t           stage_i,
  output logic                           adv_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [spt_pkg::ThrW-1:0]  cfg_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output spt_pkg::out_word_t             out_word_o
);

  localparam int unsigned PW = spt_pkg::PitchW;
  localparam int unsigned TW = spt_pkg::TimeW;
  localparam int unsigned DW = spt_pkg::DurW;

  logic [spt_pkg::ThrW-1:0] thr_q;
  logic signed [PW-1:0]     ref_q, ref_d;
  logic signed [PW-1:0]     good_q, good_d;
  logic signed [TW-1:0]     sst_q, sst_d;
  logic [DW-1:0]            ld_q, ld_d;
  logic signed [TW-1:0]     prev_q, prev_d;
  logic                     back_q, back_d;
  logic                     out_valid_q, out_valid_d;
  spt_pkg::out_word_t       out_q;
  logic [DW-1:0]            dur_res;

  logic                     fire;
  logic signed [PW-1:0]     p;
  logic signed [TW-1:0]     t;
  logic signed [PW:0]       pdiff;
  logic [PW:0]              pabs;
  logic                     pitch_ok, sign_chg, resync, refresh;
  logic signed [TW:0]       tdiff, sdiff, step_sum, rs_sum;
  logic [TW:0]              sabs;
  logic signed [TW-1:0]     sst_step, sst_eff, sst_rs;
  logic [DW-1:0]            span;

  assign adv_o = !out_valid_q || !out_stall_i;
  assign fire  = stage_i.valid && adv_o;
  assign p     = stage_i.word.pitch;
  assign t     = stage_i.word.track_time;

  always_comb begin
    pdiff    = {p[PW-1], p} - {ref_q[PW-1], ref_q};
    pabs     = pdiff[PW] ? (PW+1)'(-pdiff) : (PW+1)'(pdiff);
    pitch_ok = pabs < {2'b00, thr_q};
    sign_chg = p[PW-1] != back_q;
    resync   = back_q ? (t > prev_q) : (t < prev_q);
    // refresh check and 1 s move of the start time
    tdiff    = {t[TW-1], t} - {sst_q[TW-1], sst_q};
    refresh  = spt_pkg::abs33(tdiff) > spt_pkg::TwoSeconds;
    step_sum = back_q ? ({sst_q[TW-1], sst_q} - spt_pkg::OneSecond)
                      : ({sst_q[TW-1], sst_q} + spt_pkg::OneSecond);
    sst_step = spt_pkg::sat32(step_sum);
    sst_eff  = refresh ? sst_step : sst_q;
    sdiff    = {t[TW-1], t} - {sst_eff[TW-1], sst_eff};
    sabs     = spt_pkg::abs33(sdiff);
    span     = (sabs > {2'b00, spt_pkg::DurMax}) ? spt_pkg::DurMax : sabs[DW-1:0];
    // start time rebuilt from the kept duration on a resync
    rs_sum   = back_q ? ({t[TW-1], t} + {2'b00, ld_q}) : ({t[TW-1], t} - {2'b00, ld_q});
    sst_rs   = spt_pkg::sat32(rs_sum);
  end

  always_comb begin
    ref_d   = ref_q;
    good_d  = good_q;
    sst_d   = sst_q;
    ld_d    = ld_q;
    prev_d  = prev_q;
    back_d  = back_q;
    dur_res = '0;
    if (sign_chg || (resync && !pitch_ok) || (!resync && !pitch_ok)) begin
      // restart tracking on this word
      ref_d  = p;
      sst_d  = t;
      prev_d = t;
      back_d = p[PW-1];
      ld_d   = '0;
    end else if (resync) begin
      prev_d  = t;
      sst_d   = sst_rs;
      dur_res = ld_q;
    end else begin
      prev_d = t;
      if (refresh) begin
        ref_d  = p;
        good_d = p;
        sst_d  = sst_step;
      end
      ld_d    = span;
      dur_res = span;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= spt_pkg::ThrReset;
      ref_q       <= '0;
      good_q      <= spt_pkg::GoodPitchInit;
      sst_q       <= '0;
      ld_q        <= '0;
      prev_q      <= '0;
      back_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (fire) begin
        ref_q  <= ref_d;
        good_q <= good_d;
        sst_q  <= sst_d;
        ld_q   <= ld_d;
        prev_q <= prev_d;
        back_q <= back_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.steady_duration <= dur_res;
      out_q.steady_value    <= good_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/steady_pitch_tracker_top.sv =====
// Top level of the steady pitch tracker.
// Accepted input words pass the input register, then the result register.
// Throughput: one word per cycle unless stalled; state is written with the result word.
// Reset (rst_ni, async, active low): threshold 655, good pitch 1.0, all other state zero.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none
module steady_pitch_tracker_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input words
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire spt_pkg::in_word_t         in_word_i,
  // result words
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output spt_pkg::out_word_t             out_word_o,
  // pitch threshold register write
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [spt_pkg::ThrW-1:0]  cfg_data_i
);

  spt_pkg::stage_t stage;
  logic            adv;

  // threshold register accepts writes at any time
  assign cfg_ready_o = 1'b1;

  // input register: holds one word while the result register is stalled
  spt_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .adv_i      (adv),
    .stage_o    (stage)
  );

  // tracker: sign change, resync, refresh and saturation all resolved in one pass,
  // state and result written together when the word moves on
  spt_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .adv_o       (adv),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // accepted word lands in the input register
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> stage.valid)
    else $error("accepted word not held in input register");

  // a word leaving the input register produces a result
  a_word_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage.valid && !in_stall_o) |=> out_valid_o)
    else $error("word advanced without a result");

  // a held word cannot move while the result is blocked
  a_block_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && stage.valid) |-> in_stall_o)
    else $error("input not stalled behind a blocked result");
`endif

endmodule
`default_nettype wire
